@@ sv/qsa_pkg.sv @@
// Shared types and constants for the Q1.14 saturating ALU.
// No dependencies; imported by every module of the block.
`default_nettype none
package qsa_pkg;
  localparam int DATA_W        = 16;
  localparam int FRACTION_BITS = 14;
  localparam int DIV_STEPS     = FRACTION_BITS + 3;
  localparam int SQRT_STEPS    = DATA_W;

  localparam logic [2:0] FUNC_ADD  = 3'd0;
  localparam logic [2:0] FUNC_SUB  = 3'd1;
  localparam logic [2:0] FUNC_MUL  = 3'd2;
  localparam logic [2:0] FUNC_DIV  = 3'd3;
  localparam logic [2:0] FUNC_SQRT = 3'd4;

  localparam logic signed [DATA_W-1:0] Q_ERR = 16'sh8000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7fff;

  typedef struct packed {
    logic               mode;
    logic [2:0]         func;
    logic               err_in;
    logic               undef;
    logic signed [17:0] v;
    logic               a_neg;
    logic               b_neg;
    logic               dz;
    logic               big;
    logic [16:0]        nbits;
    logic [16:0]        drem;
    logic [15:0]        den;
    logic [16:0]        quo;
    logic [31:0]        sop;
    logic [19:0]        srem;
    logic [16:0]        root;
  } pipe_t;
endpackage
`default_nettype wire

@@ sv/q1_14_saturating_alu_unit.sv @@
// Q1.14 saturating ALU: add, subtract, multiply, divide and square root.
// Operations 0 to 4 on signed 16-bit Q1.14 operands a and b.
// Input word: in_valid/in_ready with func, a, b. Result word:
// out_valid/out_ready with result and overflow.
// One word can be accepted every cycle. There is one input stage, 17 stages
// each holding one restoring divide step, all but the last also one square
// root step, and one output stage for rounding and saturation.
// Every stage has its own valid bit and takes a new word when it is empty
// or its successor moves, so bubbles close up. When the receiver stalls,
// words pile up in the pipeline and in_ready falls only once it is full.
// Reset empties the pipeline and sets overflow_mode to saturate.
// cfg_we/cfg_wdata write overflow_mode (0 saturate, 1 error code); write
// it only while the pipeline is empty.
`default_nettype none
module q1_14_saturating_alu_unit import qsa_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               func,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      result,
  output logic                          overflow
);
  logic  mode;
  pipe_t pd  [DIV_STEPS+1];
  logic  pv  [DIV_STEPS+1];
  logic  prdy[DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  qsa_front u_front (
    .clk, .rst, .mode, .in_valid, .in_ready, .func, .a, .b,
    .out_valid(pv[0]), .out_ready(prdy[0]), .out_data(pd[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    qsa_step #(.DO_SQRT(k < SQRT_STEPS)) u_step (
      .clk, .rst,
      .in_valid(pv[k]), .in_ready(prdy[k]), .in_data(pd[k]),
      .out_valid(pv[k+1]), .out_ready(prdy[k+1]), .out_data(pd[k+1])
    );
  end

  qsa_back u_back (
    .clk, .rst,
    .in_valid(pv[DIV_STEPS]), .in_ready(prdy[DIV_STEPS]), .in_data(pd[DIV_STEPS]),
    .out_valid, .out_ready, .result, .overflow
  );

`ifndef SYNTHESIS
  a_err_flagged: assert property (@(posedge clk) disable iff (rst)
    out_valid && result == Q_ERR |-> overflow)
    else $error("error code delivered without overflow");
  a_sat_values: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> (result == Q_ERR || result == Q_MAX || result == -Q_MAX))
    else $error("overflow with a value that is not an extreme");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");
`endif
endmodule
`default_nettype wire

@@ sv/qsa_front.sv @@
// Input stage: decode, add, subtract, multiply and operand magnitudes.
// Depends on qsa_pkg.
`default_nettype none
module qsa_front import qsa_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     mode,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               func,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pipe_t                         out_data
);
  pipe_t              d;
  logic [15:0]        abs_a;
  logic [15:0]        abs_b;
  logic signed [31:0] prod;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    abs_a = a[15] ? 16'(-a) : a;
    abs_b = b[15] ? 16'(-b) : b;
    prod  = 32'(a) * 32'(b);
    d        = '0;
    d.mode   = mode;
    d.func   = func;
    d.undef  = func > FUNC_SQRT;
    d.err_in = mode && !d.undef &&
               (a == Q_ERR || (func != FUNC_SQRT && b == Q_ERR));
    case (func)
      FUNC_ADD: d.v = 18'(a) + 18'(b);
      FUNC_SUB: d.v = 18'(a) - 18'(b);
      FUNC_MUL: d.v = 18'(prod >>> FRACTION_BITS);
      default:  d.v = '0;
    endcase
    d.a_neg = a[15];
    d.b_neg = b[15];
    d.dz    = b == '0;
    // The quotient needs more than 17 bits exactly when |a| >= 4|b|.
    d.big   = {2'b00, abs_a} >= {abs_b, 2'b00};
    d.drem  = 17'(abs_a >> 2);
    d.nbits = {abs_a[1:0], 15'b0};
    d.den   = abs_b;
    d.sop   = {abs_a, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= d;
    end
  end
endmodule
`default_nettype wire

@@ sv/qsa_step.sv @@
// Pipeline stage: restoring divide step, square root step if DO_SQRT.
// Depends on qsa_pkg.
`default_nettype none
module qsa_step import qsa_pkg::*; #(
  parameter bit DO_SQRT = 1'b1
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire pipe_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output pipe_t      out_data
);
  pipe_t       d;
  logic [16:0] r1;
  logic [19:0] r2;
  logic [19:0] trial;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    d  = in_data;
    r1 = {in_data.drem[15:0], in_data.nbits[16]};
    d.nbits = {in_data.nbits[15:0], 1'b0};
    if (r1 >= {1'b0, in_data.den}) begin
      d.drem = r1 - {1'b0, in_data.den};
      d.quo  = {in_data.quo[15:0], 1'b1};
    end else begin
      d.drem = r1;
      d.quo  = {in_data.quo[15:0], 1'b0};
    end
    r2    = {in_data.srem[17:0], in_data.sop[31:30]};
    trial = {1'b0, in_data.root, 2'b01};
    if (DO_SQRT) begin
      d.sop = {in_data.sop[29:0], 2'b00};
      if (r2 >= trial) begin
        d.srem = r2 - trial;
        d.root = {in_data.root[15:0], 1'b1};
      end else begin
        d.srem = r2;
        d.root = {in_data.root[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= d;
    end
  end
endmodule
`default_nettype wire

@@ sv/qsa_back.sv @@
// Output stage: quotient and root rounding, range check, saturation.
// Depends on qsa_pkg.
`default_nettype none
module qsa_back import qsa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pipe_t               in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [DATA_W-1:0] result,
  output logic                     overflow
);
  logic signed [18:0]       q;
  logic signed [18:0]       v;
  logic signed [DATA_W-1:0] r;
  logic                     ovf;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    q = in_data.a_neg ^ in_data.b_neg ? -$signed({2'b00, in_data.quo})
                                      : $signed({2'b00, in_data.quo});
    case (in_data.func)
      FUNC_DIV: begin
        if (in_data.dz) begin
          v = in_data.a_neg ? -19'sd32768 : 19'sd32768;
        end else if (in_data.big) begin
          v = in_data.a_neg ^ in_data.b_neg ? -19'sd32768 : 19'sd32768;
        end else begin
          v = (q + 19'sd1) >>> 1;
        end
      end
      FUNC_SQRT: v = $signed(19'({2'b00, in_data.root[16:1]}) + 19'(in_data.root[0]));
      default:   v = 19'(in_data.v);
    endcase
    r   = v[15:0];
    ovf = 1'b0;
    if (v > 19'sd32767 || v < -19'sd32767) begin
      ovf = 1'b1;
      r   = in_data.mode ? Q_ERR : (v > 19'sd0 ? Q_MAX : -Q_MAX);
    end
    if (in_data.undef) begin
      r   = '0;
      ovf = 1'b0;
    end else if (in_data.err_in) begin
      r   = Q_ERR;
      ovf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      result   <= r;
      overflow <= ovf;
    end
  end
endmodule
`default_nettype wire

@@ dv/q1_14_saturating_alu_unit_test.sv @@
// Self-checking testbench for the Q1.14 saturating ALU unit.
// Depends on qsa_pkg and q1_14_saturating_alu_unit; drives words, predicts results.
`default_nettype none
module q1_14_saturating_alu_unit_test;
  import qsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    bit          fixed;
    logic [15:0] want_r;
    logic        want_o;
  } row_t;

  typedef struct {
    logic [15:0] r;
    logic        o;
  } alu_out_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] func = '0;
  logic signed [15:0] a = '0;
  logic signed [15:0] b = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] result;
  logic overflow;

  logic mode_shadow = 0;
  alu_out_t pending_results[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  bit hold_off = 0;

  q1_14_saturating_alu_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .a(a), .b(b),
    .out_valid(out_valid), .out_ready(out_ready), .result(result),
    .overflow(overflow)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("q1_14_saturating_alu_unit_test: timeout");
    $display("q1_14_saturating_alu_unit_test: errors");
    $finish;
  end

  function automatic longint isqrt_mag(longint m);
    longint op, one, res;
    op = m <<< 16;
    one = 64'd1 << 30;
    res = 0;
    while (one > op) one = one >> 2;
    while (one != 0) begin
      if (op >= res + one) begin
        op = op - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return (res >> 1) + (res & 1);
  endfunction

  function automatic alu_out_t predict_alu(logic [2:0] op, logic signed [15:0] x,
                                           logic signed [15:0] y, logic errm);
    alu_out_t o;
    longint ax, by, v, p, q, t;
    ax = x;
    by = y;
    o.r = '0;
    o.o = 1'b0;
    if (op > FUNC_SQRT) return o;
    if (errm && (x == Q_ERR || (op != FUNC_SQRT && y == Q_ERR))) begin
      o.r = Q_ERR;
      o.o = 1'b1;
      return o;
    end
    case (op)
      FUNC_ADD: v = ax + by;
      FUNC_SUB: v = ax - by;
      FUNC_MUL: begin
        p = ax * by;
        v = p >>> FRACTION_BITS;  // arithmetic shift is floor
      end
      FUNC_DIV: begin
        if (by == 0) begin
          v = (ax >= 0) ? 32768 : -32768;
        end else begin
          q = (ax * 32768) / by;  // truncates toward zero
          t = q + 1;
          v = (t >= 0) ? t / 2 : -((1 - t) / 2);
        end
      end
      default: v = isqrt_mag(ax < 0 ? -ax : ax);
    endcase
    if (v > 32767 || v < -32767) begin
      o.o = 1'b1;
      o.r = errm ? Q_ERR : (v > 0 ? Q_MAX : -Q_MAX);
    end else begin
      o.r = v[15:0];
    end
    return o;
  endfunction

  // Result side: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 0;
    end else if ($urandom_range(0, 9) < 7) begin
      out_ready <= 1;
    end else begin
      out_ready <= 0;
    end
  end

  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && in_valid && in_ready) words_in++;
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word result=%h overflow=%b", $realtime, result, overflow);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (result !== e.r || overflow !== e.o) begin
          $display("%0t: mismatch expected result=%h overflow=%b, actual result=%h overflow=%b",
                   $realtime, e.r, e.o, result, overflow);
          errors++;
        end
      end
    end
  end

  // Valid stays high between back-to-back words; it drops only for a gap.
  task automatic send_word(logic [2:0] op, logic [15:0] x, logic [15:0] y);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    func <= op;
    a <= x;
    b <= y;
    pending_results.push_back(predict_alu(op, x, y, mode_shadow));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_set(logic m);
    int guard;
    guard = 0;
    in_valid <= 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (25) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= m;
    mode_shadow = m;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_random;
    logic [15:0] x, y;
    logic [2:0] op;
    int k;
    k = $urandom_range(0, 15);
    op = (k < 14) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    x = 16'($urandom);
    y = 16'($urandom);
    case ($urandom_range(0, 7))
      0: x = 16'h8000;
      1: y = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h0000;
      2: y = 16'($urandom_range(0, 31) - 16);  // small divisors stress division
      default: ;
    endcase
    send_word(op, x, y);
  endtask

  row_t dir[] = '{
    '{FUNC_ADD, 16'h7fff, 16'h0001, 1'b1, 16'h7fff, 1'b1},
    '{FUNC_ADD, 16'h8000, 16'h0000, 1'b1, 16'h8001, 1'b1},
    '{FUNC_ADD, 16'h1234, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{FUNC_SUB, 16'h8001, 16'h0001, 1'b1, 16'h8001, 1'b1},
    '{FUNC_SUB, 16'h4000, 16'h1000, 1'b0, 16'h0000, 1'b0},
    '{FUNC_MUL, 16'h8000, 16'h8000, 1'b1, 16'h7fff, 1'b1},
    '{FUNC_MUL, 16'h4000, 16'hc000, 1'b1, 16'hc000, 1'b0},
    '{FUNC_MUL, 16'hffff, 16'h0001, 1'b0, 16'h0000, 1'b0},
    '{FUNC_DIV, 16'h1000, 16'h0000, 1'b1, 16'h7fff, 1'b1},
    '{FUNC_DIV, 16'hf000, 16'h0000, 1'b1, 16'h8001, 1'b1},
    '{FUNC_DIV, 16'h4000, 16'h0001, 1'b1, 16'h7fff, 1'b1},
    '{FUNC_DIV, 16'h2000, 16'h6000, 1'b0, 16'h0000, 1'b0},
    '{FUNC_DIV, 16'h8000, 16'h7fff, 1'b0, 16'h0000, 1'b0},
    '{FUNC_SQRT, 16'h4000, 16'h0000, 1'b1, 16'h4000, 1'b0},
    '{FUNC_SQRT, 16'h8000, 16'h1234, 1'b1, 16'h5a82, 1'b0},
    '{FUNC_SQRT, 16'h7fff, 16'hffff, 1'b0, 16'h0000, 1'b0},
    '{FUNC_SQRT, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{3'd5, 16'h7fff, 16'h7fff, 1'b1, 16'h0000, 1'b0},
    '{3'd7, 16'h8000, 16'h8000, 1'b1, 16'h0000, 1'b0}
  };

  row_t err_dir[] = '{
    '{FUNC_ADD, 16'h8000, 16'h0000, 1'b1, 16'h8000, 1'b1},
    '{FUNC_MUL, 16'h0001, 16'h8000, 1'b1, 16'h8000, 1'b1},
    '{FUNC_SQRT, 16'h8000, 16'h0000, 1'b1, 16'h8000, 1'b1},
    '{FUNC_SQRT, 16'h4000, 16'h8000, 1'b1, 16'h4000, 1'b0},
    '{FUNC_DIV, 16'h1000, 16'h0000, 1'b1, 16'h8000, 1'b1},
    '{FUNC_ADD, 16'h7fff, 16'h7fff, 1'b1, 16'h8000, 1'b1},
    '{3'd6, 16'h1111, 16'h2222, 1'b1, 16'h0000, 1'b0}
  };

  task automatic walk_table(row_t t[]);
    alu_out_t e;
    foreach (t[i]) begin
      send_word(t[i].op, t[i].x, t[i].y);
      if (t[i].fixed) begin
        // Replace the predicted value with the one read off the spec.
        e.r = t[i].want_r;
        e.o = t[i].want_o;
        pending_results[pending_results.size() - 1] = e;
      end
    end
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    walk_table(dir);
    drain_and_set(1);
    walk_table(err_dir);
    drain_and_set(0);
    repeat (250) send_random();
    // Long receiver hold-off so the pipeline fills and in_ready drops.
    hold_off = 1;
    fork
      begin
        repeat (120) @(negedge clk);
        hold_off = 0;
      end
      repeat (40) send_word(3'($urandom_range(0, 4)), 16'($urandom), 16'($urandom));
    join
    drain_and_set(1);
    repeat (300) send_random();
    drain_and_set(0);
    repeat (300) send_random();
    in_valid <= 0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
    $display("Ran %0d words in and %0d out over both overflow modes,", words_in, words_out);
    $display("including extremes, divide by zero, error inputs and a full-pipe stall.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("q1_14_saturating_alu_unit_test: clean");
    end else begin
      $display("q1_14_saturating_alu_unit_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
